// ===== rtl/ps2s1_pkg.sv =====
// Shared types, byte codes and key tables for the set 1 scan decoder.
// Used by ps2s1_decode, ps2s1_out_buf and ps2_set1_scan_decoder.
package ps2s1_pkg;

  // Prefix and sequence bytes
  localparam logic [7:0] ByteExt      = 8'hE0;
  localparam logic [7:0] BytePause    = 8'hE1;
  localparam logic [7:0] BytePrsMake  = 8'h2A;
  localparam logic [7:0] BytePrsBreak = 8'hB7;
  localparam logic [7:0] BytePauMake  = 8'h1D;
  localparam logic [7:0] BytePauBreak = 8'h45;
  localparam logic [7:0] ShiftLimit   = 8'h36;

  // Key codes from the base table that name modifier and lock keys
  localparam logic [7:0] KeyCaps   = 8'h06;
  localparam logic [7:0] KeyLShift = 8'h03;
  localparam logic [7:0] KeyRShift = 8'h04;
  localparam logic [7:0] KeyLCtrl  = 8'h02;
  localparam logic [7:0] KeyRCtrl  = 8'h1E;
  localparam logic [7:0] KeyLAlt   = 8'h05;
  localparam logic [7:0] KeyRAlt   = 8'h1F;

  localparam logic [7:0] PrintLow = 8'h20;

  typedef struct packed {
    logic [6:0] character;
    logic [7:0] scan_echo;
    logic [9:0] key_flags;
  } result_t;

  // Base key table, indexed by the low 7 bits of the scan byte
  function automatic logic [7:0] base_rom(input logic [6:0] idx);
    logic [7:0] v;
    case (idx)
      7'h01: v = 8'h1B; 7'h02: v = 8'h31; 7'h03: v = 8'h32; 7'h04: v = 8'h33;
      7'h05: v = 8'h34; 7'h06: v = 8'h35; 7'h07: v = 8'h36; 7'h08: v = 8'h37;
      7'h09: v = 8'h38; 7'h0A: v = 8'h39; 7'h0B: v = 8'h30; 7'h0C: v = 8'h2D;
      7'h0D: v = 8'h3D; 7'h0E: v = 8'h08; 7'h0F: v = 8'h09;
      7'h10: v = 8'h71; 7'h11: v = 8'h77; 7'h12: v = 8'h65; 7'h13: v = 8'h72;
      7'h14: v = 8'h74; 7'h15: v = 8'h79; 7'h16: v = 8'h75; 7'h17: v = 8'h69;
      7'h18: v = 8'h6F; 7'h19: v = 8'h70; 7'h1A: v = 8'h5B; 7'h1B: v = 8'h5D;
      7'h1C: v = 8'h0A; 7'h1D: v = 8'h02; 7'h1E: v = 8'h61; 7'h1F: v = 8'h73;
      7'h20: v = 8'h64; 7'h21: v = 8'h66; 7'h22: v = 8'h67; 7'h23: v = 8'h68;
      7'h24: v = 8'h6A; 7'h25: v = 8'h6B; 7'h26: v = 8'h6C; 7'h27: v = 8'h3B;
      7'h28: v = 8'h27; 7'h29: v = 8'h60; 7'h2A: v = 8'h03; 7'h2B: v = 8'h5C;
      7'h2C: v = 8'h7A; 7'h2D: v = 8'h78; 7'h2E: v = 8'h63; 7'h2F: v = 8'h76;
      7'h30: v = 8'h62; 7'h31: v = 8'h6E; 7'h32: v = 8'h6D; 7'h33: v = 8'h2C;
      7'h34: v = 8'h2E; 7'h35: v = 8'h2F; 7'h36: v = 8'h04; 7'h37: v = 8'h2A;
      7'h38: v = 8'h05; 7'h39: v = 8'h20; 7'h3A: v = 8'h06; 7'h3B: v = 8'h07;
      7'h3C: v = 8'h0E; 7'h3D: v = 8'h0F; 7'h3E: v = 8'h10; 7'h3F: v = 8'h11;
      7'h40: v = 8'h12; 7'h41: v = 8'h13; 7'h42: v = 8'h14; 7'h43: v = 8'h15;
      7'h44: v = 8'h16; 7'h45: v = 8'h17; 7'h46: v = 8'h18; 7'h47: v = 8'h37;
      7'h48: v = 8'h38; 7'h49: v = 8'h39; 7'h4A: v = 8'h2D; 7'h4B: v = 8'h34;
      7'h4C: v = 8'h35; 7'h4D: v = 8'h36; 7'h4E: v = 8'h2B; 7'h4F: v = 8'h31;
      7'h50: v = 8'h32; 7'h51: v = 8'h33; 7'h52: v = 8'h30; 7'h53: v = 8'h2E;
      7'h57: v = 8'h19; 7'h58: v = 8'h1A; 7'h60: v = 8'h1C; 7'h69: v = 8'h1D;
      7'h6C: v = 8'h0A; 7'h6D: v = 8'h1E;
      7'h70: v = 8'hFF; 7'h71: v = 8'hFF; 7'h72: v = 8'hFF; 7'h74: v = 8'hFF;
      7'h7E: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Shifted symbols for scan codes below 0x36; other keys keep their base char
  function automatic logic [7:0] shift_rom(input logic [5:0] idx, input logic [7:0] base);
    logic [7:0] v;
    case (idx)
      6'h02: v = 8'h21; 6'h03: v = 8'h40; 6'h04: v = 8'h23; 6'h05: v = 8'h24;
      6'h06: v = 8'h25; 6'h07: v = 8'h5E; 6'h08: v = 8'h26; 6'h09: v = 8'h2A;
      6'h0A: v = 8'h28; 6'h0B: v = 8'h29; 6'h0C: v = 8'h5F; 6'h0D: v = 8'h2B;
      6'h1A: v = 8'h7B; 6'h1B: v = 8'h7D; 6'h27: v = 8'h3A; 6'h28: v = 8'h22;
      6'h29: v = 8'h7E; 6'h2B: v = 8'h7C; 6'h33: v = 8'h3C; 6'h34: v = 8'h3E;
      6'h35: v = 8'h3F;
      default: v = base;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ps2s1_decode.sv =====
// Prefix state machine, modifier flags and character lookup for one scan byte.
// Depends on ps2s1_pkg for byte codes, key tables and the result type.
module ps2s1_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          scan_byte_i,
  output logic                res_valid_o,
  output ps2s1_pkg::result_t  res_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'd0,
    StExt    = 4'd1,
    StPrsMk1 = 4'd2,
    StPrsMk2 = 4'd3,
    StPrsBr1 = 4'd4,
    StPrsBr2 = 4'd5,
    StPau    = 4'd6,
    StPauMk  = 4'd7,
    StPauBr  = 4'd8
  } state_e;

  state_e     state_q, state_d;
  logic [9:0] flags_q, flags_d;
  logic [7:0] code;
  logic       rel;
  logic       caps, shf, letter, emit;
  logic [7:0] ch;

  assign rel = scan_byte_i[7];

  always_comb begin
    state_d = StIdle;
    code    = 8'h00;
    case (state_q)
      StExt: begin
        if (scan_byte_i == ps2s1_pkg::BytePrsMake) state_d = StPrsMk1;
        else if (scan_byte_i == ps2s1_pkg::BytePrsBreak) state_d = StPrsBr1;
      end
      StPau: begin
        if (scan_byte_i == ps2s1_pkg::BytePauMake) state_d = StPauMk;
        else if (scan_byte_i == ps2s1_pkg::BytePauBreak) state_d = StPauBr;
      end
      StPrsMk1: if (scan_byte_i == ps2s1_pkg::ByteExt) state_d = StPrsMk2;
      StPrsBr1: if (scan_byte_i == ps2s1_pkg::ByteExt) state_d = StPrsBr2;
      StPrsMk2, StPrsBr2, StPauMk, StPauBr: state_d = StIdle;
      default: begin
        // idle, and any unused code acts as idle
        if (scan_byte_i == ps2s1_pkg::ByteExt) state_d = StExt;
        else if (scan_byte_i == ps2s1_pkg::BytePause) state_d = StPau;
        else code = ps2s1_pkg::base_rom(scan_byte_i[6:0]);
      end
    endcase
  end

  always_comb begin
    flags_d    = flags_q;
    flags_d[0] = ~rel;
    case (code)
      ps2s1_pkg::KeyCaps:   if (!rel) flags_d[1] = ~flags_q[1];
      ps2s1_pkg::KeyLShift: flags_d[4] = ~rel;
      ps2s1_pkg::KeyRShift: flags_d[5] = ~rel;
      ps2s1_pkg::KeyLCtrl:  flags_d[6] = ~rel;
      ps2s1_pkg::KeyRCtrl:  flags_d[7] = ~rel;
      ps2s1_pkg::KeyLAlt:   flags_d[8] = ~rel;
      ps2s1_pkg::KeyRAlt:   flags_d[9] = ~rel;
      default: ;
    endcase
  end

  assign caps   = flags_d[1];
  assign shf    = flags_d[4] | flags_d[5];
  assign letter = (code >= 8'h61) && (code <= 8'h7A);
  assign emit   = !rel && !code[7] && (code >= ps2s1_pkg::PrintLow);

  always_comb begin
    if (letter && (caps != shf)) ch = code & 8'hDF;
    else if ((scan_byte_i < ps2s1_pkg::ShiftLimit) && shf)
      ch = ps2s1_pkg::shift_rom(scan_byte_i[5:0], code);
    else ch = code;
  end

  assign res_valid_o     = fire_i & emit;
  assign res_o.character = ch[6:0];
  assign res_o.scan_echo = scan_byte_i;
  assign res_o.key_flags = flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      flags_q <= 10'd0;
    end else if (fire_i) begin
      state_q <= state_d;
      flags_q <= flags_d;
    end
  end

endmodule

// ===== rtl/ps2s1_out_buf.sv =====
// Result register with a skid stage; a stalled receiver blocks input only once the skid is full.
// Depends on ps2s1_pkg for the result type.
module ps2s1_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ps2s1_pkg::result_t  push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ps2s1_pkg::result_t  out_data_o
);

  logic               out_valid_q, skid_valid_q;
  ps2s1_pkg::result_t out_q, skid_q;
  logic               out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      // drain the skid beat first; no push arrives while it is full
      if (skid_valid_q) out_q <= skid_q;
      else if (push_i) out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// ===== rtl/ps2_set1_scan_decoder.sv =====
// Top level of the PS/2 scan code set 1 decoder.
// Depends on ps2s1_pkg, ps2s1_decode and ps2s1_out_buf.
//
// Input channel: in_valid_i / in_stall_o with one scan byte per beat on
// scan_byte_i. Output channel: out_valid_o / out_stall_i with character_o,
// scan_echo_o and key_flags_o per beat. A beat moves at a rising edge where
// valid is high and stall is low.
// Each byte is decoded in the cycle it is accepted: prefix state and modifier
// flags update at that edge, and a printable key press yields one output beat
// that is registered in the result register, or in the skid register while the
// receiver stalls. Prefix bytes, sequence bytes, releases and non-printable keys
// yield no beat. Throughput is one byte per cycle while in_stall_o is low, set
// by the single decode stage feeding the result register.
// When the receiver stalls, the result register holds its beat and a second
// beat lands in the skid register; in_stall_o rises only while that skid
// register is occupied.
// Reset puts the prefix machine in idle, clears all flags and empties both
// output registers.
module ps2_set1_scan_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] character_o,
  output logic [7:0] scan_echo_o,
  output logic [9:0] key_flags_o
);

  logic               fire, res_valid, full;
  ps2s1_pkg::result_t res, out_data;

  assign in_stall_o = full;
  assign fire       = in_valid_i & ~full;

  ps2s1_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .scan_byte_i (scan_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ps2s1_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign character_o = out_data.character;
  assign scan_echo_o = out_data.scan_echo;
  assign key_flags_o = out_data.key_flags;

endmodule

// ===== tb/sv/ps2_set1_scan_decoder_tb.sv =====
// Self-checking testbench for the set 1 scan decoder: a directed table, then
// random key gestures, with every output beat checked against the table or a local model.
// Depends on ps2s1_pkg and the ps2_set1_scan_decoder RTL.
module ps2_set1_scan_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRows    = 37;
  localparam int RandItems  = 1600;
  localparam int WatchLimit = 4000;
  localparam int PrintCap   = 100;

  // Scan bytes that close sequences or name keys
  localparam logic [7:0] ScanPrsEnd   = 8'h37;
  localparam logic [7:0] ScanPrsBrEnd = 8'hAA;
  localparam logic [7:0] ScanPauMkEnd = 8'h9D;
  localparam logic [7:0] ScanPauBrEnd = 8'hC5;
  localparam logic [7:0] ScanCaps     = 8'h3A;
  localparam logic [7:0] ReleaseBit   = 8'h80;
  localparam logic [7:0] RomUnused    = 8'h80;
  localparam logic [7:0] CharLowA     = 8'h61;
  localparam logic [7:0] CharLowZ     = 8'h7A;
  localparam logic [7:0] CaseBit      = 8'h20;

  // Left shift, right shift, left ctrl, left alt, right ctrl
  localparam logic [7:0] ModScan [5] = '{8'h2A, 8'h36, 8'h1D, 8'h38, 8'h6D};

  typedef enum logic [3:0] {
    PfxIdle, PfxExt, PfxPrsMk1, PfxPrsMk2, PfxPrsBr1, PfxPrsBr2,
    PfxPause, PfxPauMk, PfxPauBr
  } pfx_e;

  typedef enum logic [1:0] {RowPredict, RowLit, RowNone} row_kind_e;

  typedef struct packed {
    logic [7:0] sb;
    row_kind_e  kind;
    logic [6:0] ch;
    logic [9:0] fl;
  } stim_row_t;

  localparam stim_row_t DirTab [NumRows] = '{
    '{8'h1E, RowLit, 7'h61, 10'h001},  // plain letter right after reset
    '{8'h9E, RowNone, 7'h00, 10'h000},
    '{8'h2A, RowNone, 7'h00, 10'h000},  // left shift down
    '{8'h02, RowLit, 7'h21, 10'h011},
    '{8'h35, RowLit, 7'h3F, 10'h011},  // last code of the shift table
    '{8'h37, RowLit, 7'h2A, 10'h011},  // past the shift table
    '{8'hAA, RowNone, 7'h00, 10'h000},
    '{8'h3A, RowNone, 7'h00, 10'h000},  // caps on
    '{8'h10, RowLit, 7'h51, 10'h003},
    '{8'h36, RowNone, 7'h00, 10'h000},
    '{8'h10, RowLit, 7'h71, 10'h023},  // caps and shift cancel
    '{8'hB6, RowNone, 7'h00, 10'h000},
    '{8'h3A, RowNone, 7'h00, 10'h000},  // caps off
    '{8'hFF, RowNone, 7'h00, 10'h000},
    '{8'h70, RowNone, 7'h00, 10'h000},  // unimplemented key
    '{8'h39, RowLit, 7'h20, 10'h001},  // lowest printable
    '{8'hE0, RowNone, 7'h00, 10'h000},  // print screen make
    '{8'h2A, RowNone, 7'h00, 10'h000},
    '{8'hE0, RowNone, 7'h00, 10'h000},
    '{8'h37, RowNone, 7'h00, 10'h000},
    '{8'hE0, RowPredict, 7'h00, 10'h000},  // print screen break
    '{8'hB7, RowPredict, 7'h00, 10'h000},
    '{8'hE0, RowPredict, 7'h00, 10'h000},
    '{8'hAA, RowPredict, 7'h00, 10'h000},
    '{8'hE1, RowNone, 7'h00, 10'h000},  // pause
    '{8'h1D, RowNone, 7'h00, 10'h000},
    '{8'h45, RowNone, 7'h00, 10'h000},
    '{8'hE1, RowNone, 7'h00, 10'h000},
    '{8'h9D, RowNone, 7'h00, 10'h000},
    '{8'hC5, RowNone, 7'h00, 10'h000},
    '{8'hE1, RowNone, 7'h00, 10'h000},  // pause break path swallows next byte
    '{8'h45, RowNone, 7'h00, 10'h000},
    '{8'h1E, RowNone, 7'h00, 10'h000},
    '{8'h1D, RowNone, 7'h00, 10'h000},
    '{8'h38, RowNone, 7'h00, 10'h000},
    '{8'h6D, RowNone, 7'h00, 10'h000},
    '{8'h1E, RowLit, 7'h61, 10'h1C1}   // ctrl and alt held
  };

  localparam logic [7:0] KeyTab [128] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h02, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h03, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h04, 8'h2A,
    8'h05, 8'h20, 8'h06, 8'h07, 8'h0E, 8'h0F, 8'h10, 8'h11,
    8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h19,
    8'h1A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h1D, 8'h00, 8'h00, 8'h0A, 8'h1E, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00
  };

  localparam logic [7:0] ShiftedTab [54] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0A, 8'h02, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
    8'h22, 8'h7E, 8'h03, 8'h7C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h3C, 8'h3E, 8'h3F
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] scan_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] character_o;
  logic [7:0] scan_echo_o;
  logic [9:0] key_flags_o;

  // Side data that travels with the beat for typed table rows
  row_kind_e  beat_kind = RowPredict;
  logic [6:0] beat_ch   = 7'h00;
  logic [9:0] beat_fl   = 10'h000;

  pfx_e                pfx  = PfxIdle;
  logic [9:0]          mods = 10'h000;
  ps2s1_pkg::result_t  pending_chars [$];

  int errors      = 0;
  int sent        = 0;
  int beats_in    = 0;
  int beats_out   = 0;
  int idle_cycles = 0;
  int burst_left  = 0;

  ps2_set1_scan_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scan_byte_i (scan_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .scan_echo_o (scan_echo_o),
    .key_flags_o (key_flags_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Advance the prefix machine and flags by one byte; return 1 with the
  // character beat when the byte is a printable key press.
  function automatic bit decode_scan(input logic [7:0] sb,
                                     output ps2s1_pkg::result_t res);
    logic [7:0] code;
    logic [7:0] ch;
    logic       rel;
    logic       caps;
    logic       shf;
    pfx_e       nx;
    code = 8'h00;
    nx   = PfxIdle;
    rel  = sb[7];
    res  = '0;
    case (pfx)
      PfxExt: begin
        if (sb == ps2s1_pkg::BytePrsMake) nx = PfxPrsMk1;
        else if (sb == ps2s1_pkg::BytePrsBreak) nx = PfxPrsBr1;
      end
      PfxPause: begin
        if (sb == ps2s1_pkg::BytePauMake) nx = PfxPauMk;
        else if (sb == ps2s1_pkg::BytePauBreak) nx = PfxPauBr;
      end
      PfxPrsMk1: if (sb == ps2s1_pkg::ByteExt) nx = PfxPrsMk2;
      PfxPrsBr1: if (sb == ps2s1_pkg::ByteExt) nx = PfxPrsBr2;
      PfxPrsMk2, PfxPrsBr2, PfxPauMk, PfxPauBr: nx = PfxIdle;
      default: begin
        if (sb == ps2s1_pkg::ByteExt) nx = PfxExt;
        else if (sb == ps2s1_pkg::BytePause) nx = PfxPause;
        else code = KeyTab[sb[6:0]];
      end
    endcase
    pfx = nx;
    mods[0] = ~rel;
    case (code)
      ps2s1_pkg::KeyCaps:   if (!rel) mods[1] = ~mods[1];
      ps2s1_pkg::KeyLShift: mods[4] = ~rel;
      ps2s1_pkg::KeyRShift: mods[5] = ~rel;
      ps2s1_pkg::KeyLCtrl:  mods[6] = ~rel;
      ps2s1_pkg::KeyRCtrl:  mods[7] = ~rel;
      ps2s1_pkg::KeyLAlt:   mods[8] = ~rel;
      ps2s1_pkg::KeyRAlt:   mods[9] = ~rel;
      default: ;
    endcase
    if (code >= ps2s1_pkg::PrintLow && code < RomUnused && !rel) begin
      caps = mods[1];
      shf  = mods[4] | mods[5];
      ch   = code;
      if (ch >= CharLowA && ch <= CharLowZ && (caps != shf)) ch = ch & ~CaseBit;
      else if (sb < ps2s1_pkg::ShiftLimit && shf) ch = ShiftedTab[sb[5:0]];
      res.character = ch[6:0];
      res.scan_echo = sb;
      res.key_flags = mods;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(input string what, input logic [7:0] echo, input int got,
                        input int want);
    if (errors < PrintCap)
      $display("MISMATCH %s: scan %02h got %0h want %0h", what, echo, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : monitor
    logic               acc;
    bit                 got;
    ps2s1_pkg::result_t want;
    ps2s1_pkg::result_t pred;
    if (rst_ni) begin
      acc = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        acc = 1'b1;
        beats_out++;
        if (pending_chars.size() == 0) begin
          report("unexpected beat", scan_echo_o, int'(character_o), 0);
        end else begin
          want = pending_chars.pop_front();
          if (character_o != want.character)
            report("character", want.scan_echo, int'(character_o),
                   int'(want.character));
          if (scan_echo_o != want.scan_echo)
            report("scan_echo", want.scan_echo, int'(scan_echo_o),
                   int'(want.scan_echo));
          if (key_flags_o != want.key_flags)
            report("key_flags", want.scan_echo, int'(key_flags_o),
                   int'(want.key_flags));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        acc = 1'b1;
        beats_in++;
        got = decode_scan(scan_byte_i, pred);
        case (beat_kind)
          RowLit:  pending_chars.push_back(
                     ps2s1_pkg::result_t'{beat_ch, scan_byte_i, beat_fl});
          RowNone: ;
          default: if (got) pending_chars.push_back(pred);
        endcase
      end
      idle_cycles = acc ? 0 : idle_cycles + 1;
    end
  end

  // Offer one beat and hold it until taken; then maybe pause between bursts
  task automatic offer_beat(input logic [7:0] sb, input row_kind_e kind,
                            input logic [6:0] ch, input logic [9:0] fl);
    int gap;
    in_valid_i  <= 1'b1;
    scan_byte_i <= sb;
    beat_kind   <= kind;
    beat_ch     <= ch;
    beat_fl     <= fl;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // One random keyboard gesture: mostly well-formed keys and sequences
  task automatic play_gesture();
    logic [7:0] seq [$];
    logic [7:0] k;
    int         pick;
    int         cut;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      do k = 8'($urandom_range(1, 8'h53));
      while (KeyTab[k[6:0]] < ps2s1_pkg::PrintLow || KeyTab[k[6:0]] >= RomUnused);
      seq.push_back(k);
      if ($urandom_range(0, 9) < 7) seq.push_back(k | ReleaseBit);
    end else if (pick < 55) begin
      k = ModScan[3'($urandom_range(0, 4))];
      if ($urandom_range(0, 1) == 1) k = k | ReleaseBit;
      seq.push_back(k);
    end else if (pick < 60) begin
      seq = '{ScanCaps, ScanCaps | ReleaseBit};
    end else if (pick < 68) begin
      seq = '{ps2s1_pkg::ByteExt, 8'($urandom_range(0, 255))};
    end else if (pick < 88) begin
      case ($urandom_range(0, 2))
        0: seq = '{ps2s1_pkg::ByteExt, ps2s1_pkg::BytePrsMake,
                   ps2s1_pkg::ByteExt, ScanPrsEnd};
        1: seq = '{ps2s1_pkg::ByteExt, ps2s1_pkg::BytePrsBreak,
                   ps2s1_pkg::ByteExt, ScanPrsBrEnd};
        default: seq = '{ps2s1_pkg::BytePause, ps2s1_pkg::BytePauMake,
                         ps2s1_pkg::BytePauBreak, ps2s1_pkg::BytePause,
                         ScanPauMkEnd, ScanPauBrEnd};
      endcase
      // Break the sequence off and feed a stray byte
      if (pick >= 80) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) offer_beat(seq[i], RowPredict, 7'h00, 10'h000);
  endtask

  // Receiver: random stall modes, plus two long holds to back up the input
  initial begin : receiver
    int rx_cyc;
    int mode;
    int mode_left;
    rx_cyc    = 0;
    mode      = 0;
    mode_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      if ((rx_cyc >= 500 && rx_cyc < 800) || (rx_cyc >= 1800 && rx_cyc < 2000)) begin
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 400);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((rx_cyc % 7) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (rst_ni);
    while (idle_cycles < WatchLimit) @(posedge clk_i);
    $display("timeout: no beat moved for %0d cycles", WatchLimit);
    $display("ps2_set1_scan_decoder test failed");
    $finish;
  end

  initial begin : main
    ps2s1_pkg::result_t left;
    wait (rst_ni);
    @(negedge clk_i);
    for (int i = 0; i < NumRows; i++)
      offer_beat(DirTab[i].sb, DirTab[i].kind, DirTab[i].ch, DirTab[i].fl);
    while (sent < NumRows + RandItems) play_gesture();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (pending_chars.size() != 0) begin
      left = pending_chars.pop_front();
      report("missing beat", left.scan_echo, 0, int'(left.character));
    end
    $display("%0d scan bytes in (%0d from the table), %0d characters checked",
             beats_in, NumRows, beats_out);
    $display("keys, modifiers, caps lock, E0/print screen/pause and broken sequences, %s",
             "random stalls and two long output holds");
    if (errors == 0) begin
      $display("ps2_set1_scan_decoder test passed");
    end else begin
      $display("ps2_set1_scan_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ps2s1_pkg.sv
rtl/ps2s1_decode.sv
rtl/ps2s1_out_buf.sv
rtl/ps2_set1_scan_decoder.sv
tb/sv/ps2_set1_scan_decoder_tb.sv
